FILE: rtl/core/ipv6_extension_header_builder_defines.svh
// assertion helpers for the header builder, used by iehb_back
`ifndef IPV6_EXTENSION_HEADER_BUILDER_DEFINES_SVH
`define IPV6_EXTENSION_HEADER_BUILDER_DEFINES_SVH

// consequent checked in the same cycle
`define IEHB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define IEHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/iehb_pkg.sv
package iehb_pkg;

   // request actions
   localparam logic ACT_HEADER  = 1'b0;
   localparam logic ACT_PAYLOAD = 1'b1;

   // extension header kinds
   localparam logic [2:0] KIND_HOP      = 3'd0;
   localparam logic [2:0] KIND_DEST     = 3'd1;
   localparam logic [2:0] KIND_ROUTING  = 3'd2;
   localparam logic [2:0] KIND_FRAGMENT = 3'd3;
   localparam logic [2:0] KIND_AUTH     = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_LENGTH = 2'd1;
   localparam logic [1:0] ST_KIND   = 2'd2;

   // padding option types
   localparam logic [7:0] OPT_PAD1 = 8'h00;
   localparam logic [7:0] OPT_PADN = 8'h01;

   // length limits
   localparam logic [10:0] OPT_LEN_BAD  = 11'd2047;
   localparam logic [10:0] AUTH_LEN_MAX = 11'd1016;

   // job layout and queue sizing
   localparam int JOB_BYTES   = 12;
   localparam int IDX_W       = 4;
   localparam int SPAN_W      = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   // one queued unit of work: fixed bytes, then an optional pad option
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [IDX_W-1:0]          count;
      logic [2:0]                pad;
      logic                      end_flag;
      logic [1:0]                status;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } slot_type;

endpackage

FILE: rtl/core/iehb_front.sv
module iehb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               action,
   input  logic [2:0]         header_kind,
   input  logic [7:0]         next_header,
   input  logic [10:0]        payload_length,
   input  logic [15:0]        sixteen_word,
   input  logic [12:0]        fragment_offset,
   input  logic [1:0]         reserved_bits,
   input  logic               more_fragments,
   input  logic [31:0]        word_one,
   input  logic [31:0]        word_two,
   input  logic [7:0]         payload_byte,
   output iehb_pkg::slot_type push
);
   import iehb_pkg::*;

   logic        in_header_ff, in_header_in;
   logic [10:0] remain_ff, remain_in;
   logic [2:0]  pad_ff, pad_in;

   logic [2:0]  opt_pad;
   logic [15:0] frag_word;
   logic        last;

   // pad to the next 8-octet boundary of 2 + length
   assign opt_pad   = 3'd0 - (payload_length[2:0] + 3'd2);
   assign frag_word = {fragment_offset, reserved_bits, more_fragments};
   assign last      = (remain_ff == 11'd1);

   always_comb begin
      push         = '0;
      in_header_in = in_header_ff;
      remain_in    = remain_ff;
      pad_in       = pad_ff;
      if (accept) begin
         if (action == ACT_PAYLOAD) begin
            if (in_header_ff && remain_ff != 11'd0) begin
               push.valid          = 1'b1;
               push.job.bytes[0]   = payload_byte;
               push.job.count      = IDX_W'(1);
               push.job.end_flag   = last;
               push.job.pad        = last ? pad_ff : 3'd0;
               remain_in           = remain_ff - 11'd1;
               if (last) begin
                  in_header_in = 1'b0;
                  pad_in       = 3'd0;
               end
            end
         end else begin
            push.valid   = 1'b1;
            in_header_in = 1'b0;
            remain_in    = 11'd0;
            pad_in       = 3'd0;
            push.job.bytes[0] = next_header;
            unique case (header_kind) inside
               KIND_HOP, KIND_DEST: begin
                  if (payload_length == OPT_LEN_BAD) begin
                     push.job.bytes[0] = 8'h00;
                     push.job.count    = IDX_W'(1);
                     push.job.end_flag = 1'b1;
                     push.job.status   = ST_LENGTH;
                  end else begin
                     push.job.bytes[1] = 8'((payload_length + 11'd1) >> 3);
                     push.job.count    = IDX_W'(2);
                     if (payload_length == 11'd0) begin
                        push.job.pad      = opt_pad;
                        push.job.end_flag = 1'b1;
                     end else begin
                        in_header_in = 1'b1;
                        remain_in    = payload_length;
                        pad_in       = opt_pad;
                     end
                  end
               end
               KIND_ROUTING: begin
                  if (payload_length != 11'd0 && payload_length[2:0] != 3'd4) begin
                     push.job.bytes[0] = 8'h00;
                     push.job.count    = IDX_W'(1);
                     push.job.end_flag = 1'b1;
                     push.job.status   = ST_LENGTH;
                  end else begin
                     push.job.bytes[1] = payload_length[10:3];
                     push.job.bytes[2] = sixteen_word[15:8];
                     push.job.bytes[3] = sixteen_word[7:0];
                     if (payload_length == 11'd0) begin
                        // empty routing data: four zero bytes follow
                        push.job.count    = IDX_W'(8);
                        push.job.end_flag = 1'b1;
                     end else begin
                        push.job.count = IDX_W'(4);
                        in_header_in   = 1'b1;
                        remain_in      = payload_length;
                     end
                  end
               end
               KIND_FRAGMENT: begin
                  push.job.bytes[2] = frag_word[15:8];
                  push.job.bytes[3] = frag_word[7:0];
                  push.job.bytes[4] = word_one[31:24];
                  push.job.bytes[5] = word_one[23:16];
                  push.job.bytes[6] = word_one[15:8];
                  push.job.bytes[7] = word_one[7:0];
                  push.job.count    = IDX_W'(8);
                  push.job.end_flag = 1'b1;
               end
               KIND_AUTH: begin
                  if (payload_length[1:0] != 2'd0 || payload_length > AUTH_LEN_MAX) begin
                     push.job.bytes[0] = 8'h00;
                     push.job.count    = IDX_W'(1);
                     push.job.end_flag = 1'b1;
                     push.job.status   = ST_LENGTH;
                  end else begin
                     push.job.bytes[1]  = payload_length[9:2] + 8'd1;
                     push.job.bytes[2]  = sixteen_word[15:8];
                     push.job.bytes[3]  = sixteen_word[7:0];
                     push.job.bytes[4]  = word_one[31:24];
                     push.job.bytes[5]  = word_one[23:16];
                     push.job.bytes[6]  = word_one[15:8];
                     push.job.bytes[7]  = word_one[7:0];
                     push.job.bytes[8]  = word_two[31:24];
                     push.job.bytes[9]  = word_two[23:16];
                     push.job.bytes[10] = word_two[15:8];
                     push.job.bytes[11] = word_two[7:0];
                     push.job.count     = IDX_W'(JOB_BYTES);
                     push.job.end_flag  = (payload_length == 11'd0);
                     if (payload_length != 11'd0) begin
                        in_header_in = 1'b1;
                        remain_in    = payload_length;
                     end
                  end
               end
               default: begin
                  push.job.bytes[0] = 8'h00;
                  push.job.count    = IDX_W'(1);
                  push.job.end_flag = 1'b1;
                  push.job.status   = ST_KIND;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff <= 1'b0;
         remain_ff    <= 11'd0;
         pad_ff       <= 3'd0;
      end else begin
         in_header_ff <= in_header_in;
         remain_ff    <= remain_in;
         pad_ff       <= pad_in;
      end
   end

endmodule

FILE: rtl/core/iehb_queue.sv
module iehb_queue (
   input  logic               clock,
   input  logic               reset,
   input  iehb_pkg::slot_type push,
   input  logic               pop,
   output iehb_pkg::slot_type head,
   output logic               full
);
   import iehb_pkg::*;

   job_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

FILE: rtl/core/iehb_back.sv
`include "ipv6_extension_header_builder_defines.svh"

module iehb_back (
   input  logic               clock,
   input  logic               reset,
   input  iehb_pkg::slot_type head,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);
   import iehb_pkg::*;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff;
   logic              rsp_last_ff;
   logic [1:0]        rsp_user_ff;

   logic [SPAN_W-1:0] total;
   logic [IDX_W-1:0]  pad_pos;
   logic              last;
   logic              load;
   logic [7:0]        cur_byte;

   assign total   = SPAN_W'(head.job.count) + SPAN_W'(head.job.pad);
   assign last    = (SPAN_W'(idx_ff) == total - SPAN_W'(1));
   assign pad_pos = idx_ff - head.job.count;
   assign load    = head.valid && (!rsp_valid_ff || rsp_tready);
   assign pop     = load && last;

   // fixed bytes first, then a pad1 or padn option
   always_comb begin
      cur_byte = 8'h00;
      if (idx_ff < head.job.count) begin
         cur_byte = head.job.bytes[idx_ff];
      end else if (head.job.pad == 3'd1) begin
         cur_byte = OPT_PAD1;
      end else if (pad_pos == '0) begin
         cur_byte = OPT_PADN;
      end else if (pad_pos == IDX_W'(1)) begin
         cur_byte = {5'd0, head.job.pad - 3'd2};
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load) begin
         idx_in       = last ? '0 : idx_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= cur_byte;
         rsp_last_ff <= last && head.job.end_flag;
         rsp_user_ff <= head.job.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   `IEHB_ASSERT_SAME(a_job_held, idx_ff != '0, head.valid, "job left the queue mid-emission")
   `IEHB_ASSERT_SAME(a_idx_range, load, SPAN_W'(idx_ff) < total, "byte index ran past the job")
   `IEHB_ASSERT_SAME(a_error_ends, rsp_valid_ff && rsp_user_ff != ST_OK, rsp_last_ff, "error without end")
   `IEHB_ASSERT_NEXT(a_job_continues, load && !last, head.valid && idx_ff != '0, "job dropped early")

endmodule

FILE: rtl/core/ipv6_extension_header_builder.sv
// ipv6 extension header builder
// requests arrive on the req_ channel: a header request (tuser action 0) opens one
// extension header and gives all its fixed fields, a payload request (action 1)
// carries one option or data byte of the open header
// results leave on the rsp_ channel one byte per transfer; tlast marks the final
// byte of a header or an error result, tuser carries the status
// a front stage classifies each request in the cycle it is taken and writes a job
// (up to twelve fixed bytes plus a pad option) into a four-entry queue; the back
// stage walks the head job one byte per cycle into the output register while rsp_tready allows
// the bytes of a request pass through a queue entry and then the output register
// the output carries one result byte per cycle while rsp_tready allows, so payload
// requests flow at one per cycle then; a header request yields 1 to 12 result bytes,
// the closing payload of an option header up to 8 with its pad, all set by the byte walker
// a payload request with no open header is dropped without a result
// when rsp_tready is low the output register holds, the queue fills and req_tready
// falls only once all four entries are taken
// reset clears the header tracking, the queue pointers and the output valid
module ipv6_extension_header_builder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // next_header, payload_length, sixteen_word, fragment_offset, reserved_bits,
   // more_fragments, word_one, word_two, payload_byte, zero fill
   input  logic [127:0] req_tdata,
   // action, header_kind
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_byte
   output logic [7:0]   rsp_tdata,
   // end_of_header
   output logic         rsp_tlast,
   // status
   output logic [1:0]   rsp_tuser
);
   import iehb_pkg::*;

   slot_type push_slot;
   slot_type head_slot;
   logic     queue_full;
   logic     pop;
   logic     accept;

   // a request is taken whenever the queue has room
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   iehb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .action          (req_tuser[0]),
      .header_kind     (req_tuser[3:1]),
      .next_header     (req_tdata[7:0]),
      .payload_length  (req_tdata[18:8]),
      .sixteen_word    (req_tdata[34:19]),
      .fragment_offset (req_tdata[47:35]),
      .reserved_bits   (req_tdata[49:48]),
      .more_fragments  (req_tdata[50]),
      .word_one        (req_tdata[82:51]),
      .word_two        (req_tdata[114:83]),
      .payload_byte    (req_tdata[122:115]),
      .push            (push_slot)
   );

   // job queue decouples classification from byte emission
   iehb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_slot),
      .pop   (pop),
      .head  (head_slot),
      .full  (queue_full)
   );

   iehb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_slot),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: test/ipv6_extension_header_builder_checker.sv
package iehb_request_layout_pkg;

   // request tdata layout, msb first; next_header sits in the lowest bits
   typedef struct packed {
      logic [4:0]  fill;
      logic [7:0]  payload_byte;
      logic [31:0] word_two;
      logic [31:0] word_one;
      logic        more_fragments;
      logic [1:0]  reserved_bits;
      logic [12:0] fragment_offset;
      logic [15:0] sixteen_word;
      logic [10:0] payload_length;
      logic [7:0]  next_header;
   } req_fields_type;

endpackage

module ipv6_extension_header_builder_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [3:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   input  logic         rsp_tlast,
   input  logic [1:0]   rsp_tuser,
   output int           mismatch_count,
   output int           bytes_pending,
   output int           bytes_checked
);
   import iehb_pkg::*;
   import iehb_request_layout_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic [1:0] status;
   } hdr_byte_type;

   hdr_byte_type expected_bytes[$];

   // shadow of the header tracking
   logic        hdr_open  = 1'b0;
   logic [10:0] bytes_left = '0;
   logic [2:0]  pad_owed  = '0;

   int          mismatches = 0;
   int          checked    = 0;

   task automatic push_byte(input logic [7:0] value, input logic last, input logic [1:0] status);
      hdr_byte_type e;
      e.value  = value;
      e.last   = last;
      e.status = status;
      expected_bytes.push_back(e);
   endtask

   // pad1 for a single octet, padn with its length byte and zeros otherwise
   task automatic push_pad(input logic [2:0] pad);
      int i;
      if (pad == 3'd1) begin
         push_byte(OPT_PAD1, 1'b1, ST_OK);
      end else if (pad >= 3'd2) begin
         push_byte(OPT_PADN, 1'b0, ST_OK);
         push_byte({5'd0, pad} - 8'd2, pad == 3'd2, ST_OK);
         for (i = 2; i < int'(pad); i++)
            push_byte(8'h00, i + 1 == int'(pad), ST_OK);
      end
   endtask

   task automatic push_error(input logic [1:0] status);
      hdr_open   = 1'b0;
      bytes_left = '0;
      pad_owed   = '0;
      push_byte(8'h00, 1'b1, status);
   endtask

   task automatic predict_header_bytes(input logic act, input logic [2:0] kind,
                                       input req_fields_type f);
      int          total;
      int          units;
      logic        last;
      logic [15:0] frag_word;
      if (act == ACT_PAYLOAD) begin
         // dropped when no header is open
         if (hdr_open && bytes_left != 0) begin
            bytes_left = bytes_left - 11'd1;
            last = bytes_left == 0;
            push_byte(f.payload_byte, last && pad_owed == 0, ST_OK);
            if (last) begin
               push_pad(pad_owed);
               pad_owed = '0;
               hdr_open = 1'b0;
            end
         end
      end else begin
         // a new header abandons whatever was open
         hdr_open   = 1'b0;
         bytes_left = '0;
         pad_owed   = '0;
         case (kind)
            KIND_HOP, KIND_DEST: begin
               total = 2 + int'(f.payload_length);
               units = (total + 7) / 8;
               if (units > 256) begin
                  push_error(ST_LENGTH);
               end else begin
                  push_byte(f.next_header, 1'b0, ST_OK);
                  pad_owed = 3'((8 * units - total) & 7);
                  push_byte(8'(units - 1), f.payload_length == 0 && pad_owed == 0, ST_OK);
                  if (f.payload_length == 0) begin
                     push_pad(pad_owed);
                     pad_owed = '0;
                  end else begin
                     bytes_left = f.payload_length;
                     hdr_open   = 1'b1;
                  end
               end
            end
            KIND_ROUTING: begin
               total = 4 + int'(f.payload_length);
               if (total % 8 != 0 && total != 4) begin
                  push_error(ST_LENGTH);
               end else begin
                  push_byte(f.next_header, 1'b0, ST_OK);
                  push_byte(total == 4 ? 8'd0 : 8'(total / 8 - 1), 1'b0, ST_OK);
                  push_byte(f.sixteen_word[15:8], 1'b0, ST_OK);
                  push_byte(f.sixteen_word[7:0], 1'b0, ST_OK);
                  if (total == 4) begin
                     // empty routing data gets four zero octets
                     push_byte(8'h00, 1'b0, ST_OK);
                     push_byte(8'h00, 1'b0, ST_OK);
                     push_byte(8'h00, 1'b0, ST_OK);
                     push_byte(8'h00, 1'b1, ST_OK);
                  end else begin
                     bytes_left = f.payload_length;
                     hdr_open   = 1'b1;
                  end
               end
            end
            KIND_FRAGMENT: begin
               frag_word = {f.fragment_offset, f.reserved_bits, f.more_fragments};
               push_byte(f.next_header, 1'b0, ST_OK);
               push_byte(8'h00, 1'b0, ST_OK);
               push_byte(frag_word[15:8], 1'b0, ST_OK);
               push_byte(frag_word[7:0], 1'b0, ST_OK);
               push_byte(f.word_one[31:24], 1'b0, ST_OK);
               push_byte(f.word_one[23:16], 1'b0, ST_OK);
               push_byte(f.word_one[15:8], 1'b0, ST_OK);
               push_byte(f.word_one[7:0], 1'b1, ST_OK);
            end
            KIND_AUTH: begin
               total = 12 + int'(f.payload_length);
               if (total % 4 != 0 || total > 1028) begin
                  push_error(ST_LENGTH);
               end else begin
                  push_byte(f.next_header, 1'b0, ST_OK);
                  push_byte(8'(total / 4 - 2), 1'b0, ST_OK);
                  push_byte(f.sixteen_word[15:8], 1'b0, ST_OK);
                  push_byte(f.sixteen_word[7:0], 1'b0, ST_OK);
                  push_byte(f.word_one[31:24], 1'b0, ST_OK);
                  push_byte(f.word_one[23:16], 1'b0, ST_OK);
                  push_byte(f.word_one[15:8], 1'b0, ST_OK);
                  push_byte(f.word_one[7:0], 1'b0, ST_OK);
                  push_byte(f.word_two[31:24], 1'b0, ST_OK);
                  push_byte(f.word_two[23:16], 1'b0, ST_OK);
                  push_byte(f.word_two[15:8], 1'b0, ST_OK);
                  push_byte(f.word_two[7:0], f.payload_length == 0, ST_OK);
                  if (f.payload_length != 0) begin
                     bytes_left = f.payload_length;
                     hdr_open   = 1'b1;
                  end
               end
            end
            default: push_error(ST_KIND);
         endcase
      end
   endtask

   task automatic check_result(input logic [7:0] value, input logic last,
                               input logic [1:0] status);
      hdr_byte_type e;
      checked++;
      if (expected_bytes.size() == 0) begin
         $error("result byte %02h arrived with nothing expected", value);
         mismatches++;
      end else begin
         e = expected_bytes.pop_front();
         if (value !== e.value) begin
            $error("out_byte: expected %02h, got %02h", e.value, value);
            mismatches++;
         end
         if (last !== e.last) begin
            $error("end_of_header: expected %0b, got %0b", e.last, last);
            mismatches++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
         hdr_open   = 1'b0;
         bytes_left = '0;
         pad_owed   = '0;
      end else begin
         if (req_tvalid && req_tready)
            predict_header_bytes(req_tuser[0], req_tuser[3:1], req_fields_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
      mismatch_count <= mismatches;
      bytes_pending  <= expected_bytes.size();
      bytes_checked  <= checked;
   end

endmodule

FILE: test/ipv6_extension_header_builder_tb.sv
module ipv6_extension_header_builder_tb;

   import iehb_pkg::*;
   import iehb_request_layout_pkg::*;

   // kinds above authentication have no name in the package
   localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

   // watchdog limit, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   // receiver hold-off long enough to fill the four-entry job queue
   localparam int LONG_HOLD   = 150;
   // random requests per idling phase
   localparam int PHASE_ITEMS = 120;
   // payload requests sent after a header of the largest length
   localparam int LONG_CUT    = 8;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic [3:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         rsp_tlast;
   logic [1:0]   rsp_tuser;

   int mismatch_count;
   int bytes_pending;
   int bytes_checked;

   // idling odds in percent, changed per phase by the stimulus
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // long hold-off requests from the stimulus, granted by the receiver
   int hold_asks   = 0;
   int hold_grants = 0;
   int stall_left  = 0;

   int cycle_count    = 0;
   int requests_sent  = 0;
   int headers_sent   = 0;
   int counted_items  = 0;

   always #5 clock = ~clock;

   ipv6_extension_header_builder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   ipv6_extension_header_builder_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off whenever the stimulus asks
   always @(negedge clock) begin
      if (hold_grants != hold_asks) begin
         hold_grants = hold_asks;
         stall_left  = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every field but the fill random, so each of their bits sees both values
   function automatic req_fields_type random_fields();
      req_fields_type f;
      f.fill            = '0;
      f.payload_byte    = 8'($urandom);
      f.word_two        = $urandom;
      f.word_one        = $urandom;
      f.more_fragments  = 1'($urandom);
      f.reserved_bits   = 2'($urandom);
      f.fragment_offset = 13'($urandom);
      f.sixteen_word    = 16'($urandom);
      f.payload_length  = 11'($urandom);
      f.next_header     = 8'($urandom);
      return f;
   endfunction

   // lengths the block takes without an error result
   function automatic bit length_ok(input logic [2:0] kind, input logic [10:0] len);
      case (kind)
         KIND_HOP, KIND_DEST: return len != OPT_LEN_BAD;
         KIND_ROUTING:        return len == 0 || len[2:0] == 3'd4;
         KIND_AUTH:           return len[1:0] == 2'd0 && len <= AUTH_LEN_MAX;
         default:             return 1'b0;
      endcase
   endfunction

   // offer one request from a falling edge and hold it until it is taken
   task automatic send_request(input logic act, input logic [2:0] kind,
                               input req_fields_type f);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 128'(f);
      req_tuser  <= {kind, act};
      do
         @(posedge clock);
      while (!req_tready);
      requests_sent++;
      if (act == ACT_HEADER)
         headers_sent++;
   endtask

   // one header followed by n_bytes payload requests with random content
   task automatic send_run(input logic [2:0] kind, input logic [10:0] len, input int n_bytes);
      req_fields_type f;
      int             i;
      f = random_fields();
      f.payload_length = len;
      send_request(ACT_HEADER, kind, f);
      for (i = 0; i < n_bytes; i++)
         send_request(ACT_PAYLOAD, 3'($urandom_range(KIND_RESERVED_HI)), random_fields());
      counted_items += 1 + n_bytes;
   endtask

   // mostly complete headers of small legal size, some cut short or malformed,
   // and stray payload requests while nothing is open
   task automatic random_phase(input int n_items);
      int          target;
      logic [2:0]  kind;
      logic [10:0] len;
      int          n_bytes;
      bit          closed;
      target = counted_items + n_items;
      closed = 1'b1;
      while (counted_items < target) begin
         if (closed && $urandom_range(99) < 8) begin
            send_request(ACT_PAYLOAD, 3'($urandom_range(KIND_RESERVED_HI)), random_fields());
            continue;
         end
         if ($urandom_range(99) < 10)
            kind = 3'($urandom_range(KIND_RESERVED_HI, KIND_AUTH + 1));
         else
            kind = 3'($urandom_range(KIND_AUTH));
         case (kind)
            KIND_HOP, KIND_DEST: len = 11'($urandom_range(20));
            KIND_ROUTING: len = ($urandom_range(3) == 0) ? 11'd0 : 11'(8 * $urandom_range(3) + 4);
            KIND_AUTH:    len = 11'(4 * $urandom_range(6));
            default:      len = 11'($urandom);
         endcase
         // any length at all, usually an error or a long header cut short
         if ($urandom_range(99) < 15)
            len = 11'($urandom);
         if (kind == KIND_FRAGMENT || !length_ok(kind, len))
            n_bytes = 0;
         else if (len > 32 || $urandom_range(99) < 8)
            n_bytes = $urandom_range(len < 6 ? int'(len) : 6);
         else
            n_bytes = int'(len);
         send_run(kind, len, n_bytes);
         // an unfinished header is abandoned by the next one
         closed = kind == KIND_FRAGMENT || !length_ok(kind, len) || n_bytes == int'(len);
      end
   endtask

   initial begin
      req_fields_type f;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver heavily
      send_idle_pct = 22;
      recv_idle_pct = 64;

      // directed: payload request with no open header is dropped
      send_request(ACT_PAYLOAD, KIND_HOP, random_fields());
      // hop-by-hop with no options: padn fills six octets
      f = random_fields();
      f.next_header    = 8'hFF;
      f.payload_length = '0;
      send_request(ACT_HEADER, KIND_HOP, f);
      // one option byte leaves five to pad, five leave pad1, four leave a bare padn
      send_run(KIND_DEST, 11'd1, 1);
      send_run(KIND_HOP, 11'd5, 5);
      send_run(KIND_HOP, 11'd4, 4);
      // option length that takes the header beyond 2048 octets
      f = random_fields();
      f.payload_length = OPT_LEN_BAD;
      send_request(ACT_HEADER, KIND_HOP, f);
      // routing with empty data, extreme routing words
      f = random_fields();
      f.next_header    = 8'h00;
      f.payload_length = '0;
      f.sixteen_word   = 16'hFFFF;
      send_request(ACT_HEADER, KIND_ROUTING, f);
      // routing data not on an 8-octet boundary
      f = random_fields();
      f.payload_length = 11'd3;
      send_request(ACT_HEADER, KIND_ROUTING, f);
      // fragment with every field at its top
      f = random_fields();
      f.fragment_offset = '1;
      f.reserved_bits   = '1;
      f.more_fragments  = 1'b1;
      f.word_one        = '1;
      send_request(ACT_HEADER, KIND_FRAGMENT, f);
      // authentication with no data, then one too long
      f = random_fields();
      f.payload_length = '0;
      f.word_two       = 32'h8000_0001;
      send_request(ACT_HEADER, KIND_AUTH, f);
      f = random_fields();
      f.payload_length = AUTH_LEN_MAX + 11'd4;
      send_request(ACT_HEADER, KIND_AUTH, f);
      // unsupported kind
      send_request(ACT_HEADER, KIND_RESERVED_HI, random_fields());
      // open header abandoned by a new one
      send_run(KIND_HOP, 11'd6, 1);
      f = random_fields();
      f.fragment_offset = '0;
      f.reserved_bits   = '0;
      f.more_fragments  = 1'b0;
      f.word_one        = '0;
      send_request(ACT_HEADER, KIND_FRAGMENT, f);

      random_phase(PHASE_ITEMS);
      // largest authentication length, cut short, under a long receiver hold-off
      hold_asks++;
      send_run(KIND_AUTH, AUTH_LEN_MAX, LONG_CUT);

      // phase two: the other way round
      send_idle_pct = 64;
      recv_idle_pct = 22;
      random_phase(PHASE_ITEMS);
      // largest routing length, cut short and abandoned by the next header
      send_run(KIND_ROUTING, 11'd2044, LONG_CUT);

      // phase three: no idling, then the largest option length while the
      // receiver holds off so the queue fills and the input stalls
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(PHASE_ITEMS);
      hold_asks++;
      send_run(KIND_HOP, OPT_LEN_BAD - 11'd1, LONG_CUT);

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then wait for anything unexpected to show up
      while (bytes_pending != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("sent %0d requests (%0d headers) over three idling phases and two long stalls",
               requests_sent, headers_sent);
      $display("checked %0d result bytes, %0d field mismatches", bytes_checked, mismatch_count);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/iehb_pkg.sv
rtl/core/iehb_front.sv
rtl/core/iehb_queue.sv
rtl/core/iehb_back.sv
rtl/core/ipv6_extension_header_builder.sv
test/ipv6_extension_header_builder_checker.sv
test/ipv6_extension_header_builder_tb.sv
